>>> rtl/core/pmfe_pkg.sv
// Package for the parity / Manchester frame encoder: frame sizes, codes and helper functions.
// Depends on nothing; used by the top level.
`default_nettype none

package pmfe_pkg;

  localparam int unsigned RecBits    = 49;
  localparam int unsigned Rows       = 7;
  localparam int unsigned FrameBits  = 72;
  localparam int unsigned CodedBytes = 18;

  localparam logic [4:0] TrailerRst = 5'd8;
  localparam logic [4:0] IdxFirst   = 5'd0;
  localparam logic [4:0] IdxLast    = 5'd17;

  localparam logic [1:0] SymOne  = 2'b01;
  localparam logic [1:0] SymZero = 2'b10;

  typedef logic [FrameBits-1:0] frame_t;

  // Pack record bits, add row parity in each LSB, append the column parity byte twice.
  function automatic frame_t build_frame(input logic [1:0]  version,
                                         input logic        tamper,
                                         input logic        battery_low,
                                         input logic [19:0] meter_id,
                                         input logic [19:0] meter_value,
                                         input logic [4:0]  trailer);
    logic [RecBits-1:0] bits;
    logic [6:0]         row;
    logic [7:0]         rbyte;
    logic [7:0]         col;
    frame_t             frm;
    bits = {version, tamper, battery_low, meter_id, meter_value, trailer};
    col  = '0;
    frm  = '0;
    for (int r = 0; r < Rows; r++) begin
      row   = bits[RecBits-1-7*r -: 7];
      rbyte = {row, ^row};
      col   = col ^ rbyte;
      frm[FrameBits-1-8*r -: 8] = rbyte;
    end
    frm[15:0] = {col, col};
    return frm;
  endfunction

  // Four data bits, MSB first, to four Manchester symbols (1 -> 01, 0 -> 10).
  function automatic logic [7:0] manchester(input logic [3:0] nib);
    logic [7:0] coded;
    coded = '0;
    for (int b = 0; b < 4; b++) begin
      coded[2*b +: 2] = nib[b] ? SymOne : SymZero;
    end
    return coded;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmfe_if.sv
// Valid/ready channel interfaces for the record input and the coded byte output.
// Depends on nothing.
`default_nettype none

interface pmfe_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  version;
  logic        tamper;
  logic        battery_low;
  logic [19:0] meter_id;
  logic [19:0] meter_value;

  modport source (output valid, version, tamper, battery_low, meter_id, meter_value,
                  input ready);
  modport sink   (input valid, version, tamper, battery_low, meter_id, meter_value,
                  output ready);
endinterface

interface pmfe_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic [4:0] byte_index;
  logic       last;

  modport source (output valid, coded_byte, byte_index, last, input ready);
  modport sink   (input valid, coded_byte, byte_index, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/parity_manchester_frame_encoder.sv
// Top level of the parity / Manchester frame encoder.
// Depends on pmfe_pkg and on the channel interfaces in pmfe_if.sv.
//
// One telemetry record in, eighteen Manchester coded bytes out. The record
// (version, tamper, battery_low, meter_id, meter_value) plus the configured
// 5-bit trailer is packed MSB first into seven 7-bit rows, each row gets an
// even parity LSB, and a column parity byte is appended twice. The nine bytes
// go out as eighteen bytes of four Manchester symbols each (1 -> 01, 0 -> 10),
// with byte_index 0..17 and last set on index 17. The output channel carries
// one coded byte per cycle while the sink keeps ready high: the output byte
// stream is what sets the rate. A record held in the input register waits
// while the previous frame drains, so the next record is taken during that
// drain and frames follow back to back with no gap. The record passes through
// the input register, the frame shifter and the output register before its
// first coded byte is valid. The trailer is sampled when a record is accepted;
// write it only while the block is idle. No clearing pass after reset.
`default_nettype none

module parity_manchester_frame_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  pmfe_rec_if.sink        rec_i,
  pmfe_code_if.source     code_o
);

  // Config register.
  logic [4:0] trailer_q;

  // Input register: one record plus the trailer it was taken with.
  logic        pend_vld_q;
  logic [1:0]  pend_ver_q;
  logic        pend_tmp_q;
  logic        pend_bat_q;
  logic [19:0] pend_id_q;
  logic [19:0] pend_val_q;
  logic [4:0]  pend_trl_q;

  // Frame shifter: the nine frame bytes, top nibble is the next to code.
  logic             frm_vld_q;
  pmfe_pkg::frame_t frm_q, frm_d;
  logic [4:0]       cnt_q;

  // Output register.
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic [4:0] out_idx_q;
  logic       out_last_q;

  logic rec_take;
  logic out_free;
  logic emit;
  logic frm_done;
  logic frm_take;

  assign rec_i.ready = !pend_vld_q;
  assign rec_take    = rec_i.valid && rec_i.ready;

  assign out_free = !out_vld_q || code_o.ready;
  assign emit     = out_free && frm_vld_q;
  assign frm_done = emit && (cnt_q == pmfe_pkg::IdxLast);
  // Load the next frame when the shifter is empty or hands out its last byte.
  assign frm_take = pend_vld_q && (!frm_vld_q || frm_done);

  always_comb begin
    frm_d = pmfe_pkg::build_frame(pend_ver_q, pend_tmp_q, pend_bat_q,
                                  pend_id_q, pend_val_q, pend_trl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trailer_q <= pmfe_pkg::TrailerRst;
    end else if (cfg_we_i) begin
      trailer_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (rec_take) begin
      pend_vld_q <= 1'b1;
    end else if (frm_take) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take) begin
      pend_ver_q <= rec_i.version;
      pend_tmp_q <= rec_i.tamper;
      pend_bat_q <= rec_i.battery_low;
      pend_id_q  <= rec_i.meter_id;
      pend_val_q <= rec_i.meter_value;
      pend_trl_q <= trailer_q;
    end
  end

  // Frame shifter control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_vld_q <= 1'b0;
      cnt_q     <= pmfe_pkg::IdxFirst;
    end else if (frm_take) begin
      frm_vld_q <= 1'b1;
      cnt_q     <= pmfe_pkg::IdxFirst;
    end else if (frm_done) begin
      frm_vld_q <= 1'b0;
      cnt_q     <= pmfe_pkg::IdxFirst;
    end else if (emit) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_take) begin
      frm_q <= frm_d;
    end else if (emit) begin
      frm_q <= {frm_q[pmfe_pkg::FrameBits-5:0], 4'b0000};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= pmfe_pkg::manchester(frm_q[pmfe_pkg::FrameBits-1 -: 4]);
      out_idx_q  <= cnt_q;
      out_last_q <= (cnt_q == pmfe_pkg::IdxLast);
    end
  end

  assign code_o.valid      = out_vld_q;
  assign code_o.coded_byte = out_byte_q;
  assign code_o.byte_index = out_idx_q;
  assign code_o.last       = out_last_q;

  // The byte counter only runs while a frame is loaded.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != pmfe_pkg::IdxFirst) |-> frm_vld_q)
    else $error("byte counter running with no frame loaded");

  // Last flag marks exactly the final coded byte.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_last_q == (out_idx_q == pmfe_pkg::IdxLast)))
    else $error("last flag does not match byte index");

  // A transaction with index k is followed by k+1; this check covers only k+1 within a frame, not the wrap to 0.
  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && code_o.ready && !out_last_q && frm_vld_q) |=>
      (out_vld_q && out_idx_q == $past(out_idx_q) + 5'd1))
    else $error("coded byte index skipped or repeated");

endmodule

`default_nettype wire
